[hw/rtl/soilh_pkg.sv]
package soilh_pkg;

  localparam int unsigned ADC_FULL_SCALE = 4095;
  localparam int unsigned R_SCALE        = 10000;

  localparam int unsigned ADC_W  = 12;
  localparam int unsigned RES_W  = 26;
  localparam int unsigned BAND_W = 3;
  localparam int unsigned HUM_W  = 10;

  localparam int unsigned DEN_W  = $clog2(ADC_FULL_SCALE + 1);

endpackage

[hw/rtl/soilh_div.sv]
module soilh_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [soilh_pkg::RES_W-1:0] num_i,
  input  logic [soilh_pkg::DEN_W-1:0] den_i,
  input  logic                      open_i,
  output logic                      valid_o,
  output logic [soilh_pkg::RES_W-1:0] quo_o,
  output logic                      open_o
);
  import soilh_pkg::*;

  localparam int unsigned NST = RES_W;

  logic             cur_vld  [NST];
  logic [RES_W-1:0] cur_nq   [NST];
  logic [DEN_W-1:0] cur_rem  [NST];
  logic [DEN_W-1:0] cur_den  [NST];
  logic             cur_open [NST];

  logic [RES_W-1:0] nq_d   [NST];
  logic [DEN_W-1:0] rem_d  [NST];

  logic             vld_q  [NST];
  logic [RES_W-1:0] nq_q   [NST];
  logic [DEN_W-1:0] rem_q  [NST];
  logic [DEN_W-1:0] den_q  [NST];
  logic             open_q [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    if (s == 0) begin : g_first
      assign cur_vld[s]  = valid_i;
      assign cur_nq[s]   = num_i;
      assign cur_rem[s]  = '0;
      assign cur_den[s]  = den_i;
      assign cur_open[s] = open_i;
    end else begin : g_next
      assign cur_vld[s]  = vld_q[s-1];
      assign cur_nq[s]   = nq_q[s-1];
      assign cur_rem[s]  = rem_q[s-1];
      assign cur_den[s]  = den_q[s-1];
      assign cur_open[s] = open_q[s-1];
    end

    assign trial    = {cur_rem[s], cur_nq[s][RES_W-1]};
    assign diff     = trial - {1'b0, cur_den[s]};
    assign ge       = (trial >= {1'b0, cur_den[s]});
    assign rem_d[s] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign nq_d[s]  = {cur_nq[s][RES_W-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= cur_vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[s]   <= nq_d[s];
        rem_q[s]  <= rem_d[s];
        den_q[s]  <= cur_den[s];
        open_q[s] <= cur_open[s];
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign quo_o   = nq_q[NST-1];
  assign open_o  = open_q[NST-1];

endmodule

[hw/rtl/soilh_hum.sv]
module soilh_hum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [soilh_pkg::RES_W-1:0]  res_i,
  input  logic                        open_i,
  output logic                        valid_o,
  output logic [soilh_pkg::RES_W-1:0]  res_o,
  output logic [soilh_pkg::BAND_W-1:0] band_o,
  output logic [soilh_pkg::HUM_W-1:0]  hum_o,
  output logic                        open_o
);
  import soilh_pkg::*;

  localparam int unsigned SEG_W  = 3;
  localparam int unsigned D_W    = 16;
  localparam int unsigned COEF_W = 9;
  localparam int unsigned X_W    = 25;
  localparam int unsigned DV_W   = 16;
  localparam int unsigned RCP_K  = 40;
  localparam int unsigned RCP_W  = 27;
  localparam int unsigned P_W    = X_W + RCP_W;

  localparam logic [SEG_W-1:0] SEG_DRY  = 3'd0;
  localparam logic [SEG_W-1:0] SEG_S1   = 3'd1;
  localparam logic [SEG_W-1:0] SEG_S2   = 3'd2;
  localparam logic [SEG_W-1:0] SEG_S3   = 3'd3;
  localparam logic [SEG_W-1:0] SEG_WET  = 3'd4;

  localparam int unsigned ANCHOR_100K = 100000;
  localparam int unsigned ANCHOR_50K  = 50000;
  localparam int unsigned ANCHOR_20K  = 20000;
  localparam int unsigned ANCHOR_10K  = 10000;

  localparam logic [DV_W-1:0] DV_50K = DV_W'(50000);
  localparam logic [DV_W-1:0] DV_30K = DV_W'(30000);
  localparam logic [DV_W-1:0] DV_10K = DV_W'(10000);

  localparam logic [RCP_W-1:0] RCP_50K = RCP_W'((64'd1 << RCP_K) / 64'd50000);
  localparam logic [RCP_W-1:0] RCP_30K = RCP_W'((64'd1 << RCP_K) / 64'd30000);
  localparam logic [RCP_W-1:0] RCP_10K = RCP_W'((64'd1 << RCP_K) / 64'd10000);

  localparam logic [BAND_W-1:0] BAND_1 = BAND_W'(1);
  localparam logic [BAND_W-1:0] BAND_2 = BAND_W'(2);
  localparam logic [BAND_W-1:0] BAND_3 = BAND_W'(3);
  localparam logic [BAND_W-1:0] BAND_4 = BAND_W'(4);

  typedef struct packed {
    logic [RES_W-1:0]  res;
    logic [BAND_W-1:0] band;
    logic              open;
    logic [HUM_W-1:0]  base;
    logic [SEG_W-1:0]  seg;
  } side_t;

  // stage 1: segment select
  side_t             s1_d, s1_q;
  logic [D_W-1:0]    dlt_d, dlt_q;
  logic [COEF_W-1:0] coef_d, coef_q;
  logic              v1_q;

  always_comb begin
    s1_d.res  = res_i;
    s1_d.open = open_i;
    s1_d.band = BAND_1;
    s1_d.base = '0;
    s1_d.seg  = SEG_DRY;
    dlt_d     = '0;
    coef_d    = COEF_W'(333);
    if (open_i) begin
      s1_d.res = '0;
    end else if (res_i >= RES_W'(ANCHOR_100K)) begin
      s1_d.band = BAND_1;
    end else if (res_i >= RES_W'(ANCHOR_50K)) begin
      s1_d.band = BAND_2;
      s1_d.seg  = SEG_S1;
      dlt_d     = D_W'(RES_W'(ANCHOR_100K) - res_i);
    end else if (res_i >= RES_W'(ANCHOR_20K)) begin
      s1_d.band = BAND_3;
      s1_d.seg  = SEG_S2;
      s1_d.base = HUM_W'(333);
      coef_d    = COEF_W'(334);
      dlt_d     = D_W'(RES_W'(ANCHOR_50K) - res_i);
    end else if (res_i >= RES_W'(ANCHOR_10K)) begin
      s1_d.band = BAND_4;
      s1_d.seg  = SEG_S3;
      s1_d.base = HUM_W'(667);
      dlt_d     = D_W'(RES_W'(ANCHOR_20K) - res_i);
    end else begin
      s1_d.band = BAND_4;
      s1_d.seg  = SEG_WET;
      s1_d.base = HUM_W'(1000);
    end
  end

  // stage 2: scale by slope
  side_t          s2_q;
  logic [X_W-1:0] x2_d, x2_q;
  logic           v2_q;

  assign x2_d = X_W'(dlt_q) * X_W'(coef_q);

  // stage 3: reciprocal estimate
  side_t            s3_q;
  logic [X_W-1:0]   x3_q;
  logic [RCP_W-1:0] rcp;
  logic [P_W-1:0]   prod;
  logic [HUM_W-1:0] q0_d, q0_q;
  logic             v3_q;

  always_comb begin
    case (s2_q.seg)
      SEG_S1:  rcp = RCP_50K;
      SEG_S2:  rcp = RCP_30K;
      default: rcp = RCP_10K;
    endcase
  end

  assign prod = P_W'(x2_q) * P_W'(rcp);
  assign q0_d = HUM_W'(prod >> RCP_K);

  // stage 4: correct and add base
  logic [DV_W-1:0]   dv;
  logic [X_W-1:0]    qd;
  logic [X_W-1:0]    rem;
  logic [HUM_W-1:0]  q;
  logic [HUM_W-1:0]  hum_d, hum_q;
  logic [RES_W-1:0]  res_q;
  logic [BAND_W-1:0] band_q;
  logic              open_q;
  logic              v4_q;

  always_comb begin
    case (s3_q.seg)
      SEG_S1:  dv = DV_50K;
      SEG_S2:  dv = DV_30K;
      default: dv = DV_10K;
    endcase
  end

  assign qd    = X_W'(X_W'(q0_q) * X_W'(dv));
  assign rem   = x3_q - qd;
  assign q     = (rem >= X_W'(dv)) ? q0_q + HUM_W'(1) : q0_q;
  assign hum_d = s3_q.base + q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q   <= s1_d;
      dlt_q  <= dlt_d;
      coef_q <= coef_d;
      s2_q   <= s1_q;
      x2_q   <= x2_d;
      s3_q   <= s2_q;
      x3_q   <= x2_q;
      q0_q   <= q0_d;
      res_q  <= s3_q.res;
      band_q <= s3_q.band;
      open_q <= s3_q.open;
      hum_q  <= hum_d;
    end
  end

  assign valid_o = v4_q;
  assign res_o   = res_q;
  assign band_o  = band_q;
  assign hum_o   = hum_q;
  assign open_o  = open_q;

endmodule

[hw/rtl/soil_probe_adc_to_humidity_core.sv]
// Channel  Direction  Handshake                Payload
// in       sink       in_valid_i / in_ready_o  adc_sample_i
// out      source     out_valid_o/ out_ready_i resistance_o, band_o, humidity_tenths_o,
//                                              open_circuit_o
//
// One sample per cycle unless the output stalls. Stages: one input stage, one stage per
// quotient bit of the 26-bit restoring divider, four stages of band and interpolation.
// Reset clears only the valid bits along the pipeline.
// A stalled output holds the whole pipeline; in_ready_o follows out_ready_i while
// the output register is full.
module soil_probe_adc_to_humidity_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [soilh_pkg::ADC_W-1:0]  adc_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [soilh_pkg::RES_W-1:0]  resistance_o,
  output logic [soilh_pkg::BAND_W-1:0] band_o,
  output logic [soilh_pkg::HUM_W-1:0]  humidity_tenths_o,
  output logic                         open_circuit_o
);
  import soilh_pkg::*;

  logic             en;
  logic             vld_q;
  logic [ADC_W-1:0] adc_q;
  logic             open_c;
  logic [RES_W-1:0] num;
  logic [DEN_W-1:0] den;

  logic             dv_vld;
  logic [RES_W-1:0] dv_quo;
  logic             dv_open;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      adc_q <= adc_sample_i;
    end
  end

  // full scale counts as open circuit: feed 0/1 to the divider
  assign open_c = (32'(adc_q) >= ADC_FULL_SCALE);
  assign num    = open_c ? '0 : RES_W'(RES_W'(adc_q) * RES_W'(R_SCALE));
  assign den    = open_c ? DEN_W'(1)
                         : DEN_W'(DEN_W'(ADC_FULL_SCALE) - DEN_W'(adc_q));

  soilh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q),
    .num_i   (num),
    .den_i   (den),
    .open_i  (open_c),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .open_o  (dv_open)
  );

  soilh_hum u_hum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_vld),
    .res_i   (dv_quo),
    .open_i  (dv_open),
    .valid_o (out_valid_o),
    .res_o   (resistance_o),
    .band_o  (band_o),
    .hum_o   (humidity_tenths_o),
    .open_o  (open_circuit_o)
  );

endmodule
